>>> rtl/core/g2e_pkg.sv
// Shared constants, types and rounding helpers for the geodetic to ECEF converter.
// No dependencies.
package g2e_pkg;

    localparam int ANGLE_BITS_DEF    = 32;
    localparam int CORDIC_STAGES_DEF = 24;

    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 35;
    localparam int RAD_LAT     = SQRT_STAGES + DIV_STAGES + 1;

    localparam int AXIS_W = 33;
    localparam int ECC_W  = 26;
    localparam int CFG_W  = 33;
    localparam int N_W    = 35;

    localparam logic [AXIS_W-1:0] AXIS_RESET = 33'd6378137000;
    localparam logic [ECC_W-1:0]  ECC_RESET  = 26'd28752143;

    // register indexes
    localparam logic CFG_AXIS = 1'b0;
    localparam logic CFG_ECC  = 1'b1;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;

    localparam logic signed [39:0] OUT_MAX = 40'sd8589934591;
    localparam logic signed [39:0] OUT_MIN = -40'sd8589934592;

    typedef logic signed [31:0] t_ang;
    typedef logic signed [31:0] t_trig;
    typedef logic signed [33:0] t_coord;

    // arctangent of 2^-i in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURNS [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // magnitude product / 2^30, round half away from zero, sign applied
    function automatic logic signed [39:0] f_rnd(input logic [67:0] p, input logic neg);
        logic [68:0] s;
        logic [39:0] m;
        s = {1'b0, p} + 69'h0_0000_0000_2000_0000;
        m = {1'b0, s[68:30]};
        f_rnd = neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic t_coord f_sat(input logic signed [39:0] v);
        if (v > OUT_MAX) begin
            f_sat = 34'sh1_FFFF_FFFF;
        end else if (v < OUT_MIN) begin
            f_sat = -34'sh2_0000_0000;
        end else begin
            f_sat = v[33:0];
        end
    endfunction

endpackage

>>> rtl/core/g2e_in_if.sv
// Input channel: one geodetic point per beat.
// Depends on g2e_pkg.
interface g2e_in_if;
    logic                valid;
    logic                ready;
    g2e_pkg::t_ang       latitude;
    g2e_pkg::t_ang       longitude;
    logic signed [27:0]  height_mm;

    modport source (output valid, latitude, longitude, height_mm, input ready);
    modport sink   (input valid, latitude, longitude, height_mm, output ready);
endinterface

>>> rtl/core/g2e_out_if.sv
// Output channel: one ECEF point per beat.
// Depends on g2e_pkg.
interface g2e_out_if;
    logic            valid;
    logic            ready;
    g2e_pkg::t_coord x_mm;
    g2e_pkg::t_coord y_mm;
    g2e_pkg::t_coord z_mm;

    modport source (output valid, x_mm, y_mm, z_mm, input ready);
    modport sink   (input valid, x_mm, y_mm, z_mm, output ready);
endinterface

>>> rtl/core/geodetic_to_ecef.sv
// Geodetic (lat, lon, h) to ECEF (X, Y, Z) converter, top level.
// Depends on g2e_pkg, g2e_in_if, g2e_out_if, g2e_cordic, g2e_radius.
//
//  channel   dir  flow          payload
//  i_pt      in   valid/ready   latitude, longitude (32b angle), height_mm (28b)
//  o_ecef    out  valid/ready   x_mm, y_mm, z_mm (34b signed)
//  i_cfg_*   in   write only    idx 0: semi-major axis, idx 1: e2 * 2^32
//
// One beat per cycle while the output is not held; the path runs through the CORDIC
// stages, the 32-stage root pipe and the 35-stage quotient pipe.
// Reset (sync, active low) clears the valid bits and loads WGS 84 values.
// A stall at the output freezes the whole pipe; nothing is dropped or doubled.
module geodetic_to_ecef #(
    parameter int ANGLE_BITS    = g2e_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = g2e_pkg::CORDIC_STAGES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [g2e_pkg::CFG_W-1:0]   i_cfg_data,
    g2e_in_if.sink                      i_pt,
    g2e_out_if.source                   o_ecef
);
    localparam int CLAT = CORDIC_STAGES + 2;         // cordic latency
    localparam int DTRIG = 4 + g2e_pkg::RAD_LAT;     // cordic out -> N
    localparam int DH = CLAT + DTRIG;                // input -> N
    localparam int LAT = DH + 5;

    // configuration
    logic [g2e_pkg::AXIS_W-1:0] r_axis;
    logic [g2e_pkg::ECC_W-1:0]  r_ecc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis <= g2e_pkg::AXIS_RESET;
            r_ecc  <= g2e_pkg::ECC_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                g2e_pkg::CFG_AXIS: r_axis <= i_cfg_data[g2e_pkg::AXIS_W-1:0];
                g2e_pkg::CFG_ECC:  r_ecc  <= i_cfg_data[g2e_pkg::ECC_W-1:0];
                default: ;
            endcase
        end
    end

    // global advance: the pipe moves unless the output beat is held
    logic           en;
    logic [LAT-1:0] r_vld;

    assign en         = !r_vld[LAT-1] || o_ecef.ready;
    assign i_pt.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_pt.valid};
        end
    end

    // sines and cosines
    g2e_pkg::t_trig sl, cl, so, co;

    g2e_cordic #(.ANGLE_BITS(ANGLE_BITS), .STAGES(CORDIC_STAGES)) u_lat (
        .i_clk(i_clk), .i_en(en), .i_angle(i_pt.latitude), .o_sin(sl), .o_cos(cl)
    );
    g2e_cordic #(.ANGLE_BITS(ANGLE_BITS), .STAGES(CORDIC_STAGES)) u_lon (
        .i_clk(i_clk), .i_en(en), .i_angle(i_pt.longitude), .o_sin(so), .o_cos(co)
    );

    // side delay lines: height from the input, trig values from the cordic
    logic signed [27:0] r_hd  [0:DH-1];
    g2e_pkg::t_trig     r_sld [0:DTRIG-1];
    g2e_pkg::t_trig     r_cld [0:DTRIG-1];
    g2e_pkg::t_trig     r_sod [0:DTRIG-1];
    g2e_pkg::t_trig     r_cod [0:DTRIG-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hd[0] <= i_pt.height_mm;
            for (int k = 1; k < DH; k++) begin
                r_hd[k] <= r_hd[k-1];
            end
            r_sld[0] <= sl;
            r_cld[0] <= cl;
            r_sod[0] <= so;
            r_cod[0] <= co;
            for (int k = 1; k < DTRIG; k++) begin
                r_sld[k] <= r_sld[k-1];
                r_cld[k] <= r_cld[k-1];
                r_sod[k] <= r_sod[k-1];
                r_cod[k] <= r_cod[k-1];
            end
        end
    end

    // S1..S4: sin^2 lat, e2 sin^2 lat, w = 1 - e2 sin^2 lat (Q32)
    logic [31:0] sl_mag;
    logic [63:0] r_sq;
    logic [68:0] sq_rnd;
    logic [32:0] r_s2;
    logic [58:0] r_t;
    logic [32:0] r_w;

    assign sl_mag = sl[31] ? 32'(-sl) : 32'(sl);
    assign sq_rnd = {5'd0, r_sq} + 69'h0_0000_0000_2000_0000;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq <= sl_mag * sl_mag;
            r_s2 <= sq_rnd[62:30];
            r_t  <= r_ecc * r_s2;
            r_w  <= 33'h1_0000_0000 - {4'd0, r_t[58:30]};
        end
    end

    logic [g2e_pkg::N_W-1:0] n_val;

    g2e_radius u_rad (
        .i_clk(i_clk), .i_en(en), .i_w(r_w), .i_axis(r_axis), .o_n(n_val)
    );

    // S5: N + h, e2 * N
    logic signed [36:0] r5_nh;
    logic [60:0]        r5_e2p;
    logic [34:0]        r5_n;
    logic signed [27:0] r5_h;
    g2e_pkg::t_trig     r5_sl, r5_cl, r5_so, r5_co;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_nh  <= $signed({2'b00, n_val}) + 37'(r_hd[DH-1]);
            r5_e2p <= r_ecc * n_val;
            r5_n   <= n_val;
            r5_h   <= r_hd[DH-1];
            r5_sl  <= r_sld[DTRIG-1];
            r5_cl  <= r_cld[DTRIG-1];
            r5_so  <= r_sod[DTRIG-1];
            r5_co  <= r_cod[DTRIG-1];
        end
    end

    // S6: (N + h) cos lat product, z term (1 - e2) N + h
    logic [35:0] nh_mag;
    logic [31:0] cl_mag;
    logic [61:0] e2n_rnd;
    logic [67:0]        r6_p1;
    logic               r6_neg1;
    logic signed [36:0] r6_zt;
    g2e_pkg::t_trig     r6_sl, r6_so, r6_co;

    assign nh_mag  = r5_nh[36] ? 36'(-r5_nh) : 36'(r5_nh);
    assign cl_mag  = r5_cl[31] ? 32'(-r5_cl) : 32'(r5_cl);
    assign e2n_rnd = {1'b0, r5_e2p} + 62'h0000_0000_8000_0000;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_p1   <= nh_mag * cl_mag;
            r6_neg1 <= r5_nh[36] ^ r5_cl[31];
            r6_zt   <= $signed({2'b00, r5_n}) - $signed({7'd0, e2n_rnd[61:32]})
                       + 37'(r5_h);
            r6_sl   <= r5_sl;
            r6_so   <= r5_so;
            r6_co   <= r5_co;
        end
    end

    // S7: round first product, z product
    logic [35:0] zt_mag;
    logic [31:0] sl6_mag;
    logic signed [39:0] r7_m1;
    logic [67:0]        r7_pz;
    logic               r7_negz;
    g2e_pkg::t_trig     r7_so, r7_co;

    assign zt_mag  = r6_zt[36] ? 36'(-r6_zt) : 36'(r6_zt);
    assign sl6_mag = r6_sl[31] ? 32'(-r6_sl) : 32'(r6_sl);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_m1   <= g2e_pkg::f_rnd(r6_p1, r6_neg1);
            r7_pz   <= zt_mag * sl6_mag;
            r7_negz <= r6_zt[36] ^ r6_sl[31];
            r7_so   <= r6_so;
            r7_co   <= r6_co;
        end
    end

    // S8: longitude products, finish z
    logic [35:0] m1_mag;
    logic [31:0] co_mag, so_mag;
    logic [67:0]     r8_px, r8_py;
    logic            r8_negx, r8_negy;
    g2e_pkg::t_coord r8_z;

    assign m1_mag = r7_m1[39] ? 36'(-r7_m1) : 36'(r7_m1);
    assign co_mag = r7_co[31] ? 32'(-r7_co) : 32'(r7_co);
    assign so_mag = r7_so[31] ? 32'(-r7_so) : 32'(r7_so);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_px   <= m1_mag * co_mag;
            r8_py   <= m1_mag * so_mag;
            r8_negx <= r7_m1[39] ^ r7_co[31];
            r8_negy <= r7_m1[39] ^ r7_so[31];
            r8_z    <= g2e_pkg::f_sat(g2e_pkg::f_rnd(r7_pz, r7_negz));
        end
    end

    // S9: output register
    g2e_pkg::t_coord r_x, r_y, r_z;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x <= g2e_pkg::f_sat(g2e_pkg::f_rnd(r8_px, r8_negx));
            r_y <= g2e_pkg::f_sat(g2e_pkg::f_rnd(r8_py, r8_negy));
            r_z <= r8_z;
        end
    end

    assign o_ecef.valid = r_vld[LAT-1];
    assign o_ecef.x_mm  = r_x;
    assign o_ecef.y_mm  = r_y;
    assign o_ecef.z_mm  = r_z;

`ifndef SYNTHESIS
    // a held output beat must block the input
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAT-1] && !o_ecef.ready) |-> !i_pt.ready)
        else $error("input taken while output held");

    // a frozen pipe keeps its valid bits
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en && $past(i_rst_n)) |=> $stable(r_vld))
        else $error("valid bits moved during stall");

    // a beat one stage from the end arrives at the output after an advance
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vld[LAT-2]) |=> o_ecef.valid)
        else $error("beat lost before output");
`endif
endmodule

>>> rtl/core/g2e_cordic.sv
// Pipelined rotation CORDIC: sine and cosine of a binary angle, Q30.
// Depends on g2e_pkg. The folded angle, each rotation stage and the outputs are registered.
module g2e_cordic #(
    parameter int ANGLE_BITS = g2e_pkg::ANGLE_BITS_DEF,
    parameter int STAGES     = g2e_pkg::CORDIC_STAGES_DEF
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  g2e_pkg::t_ang     i_angle,
    output g2e_pkg::t_trig    o_sin,
    output g2e_pkg::t_trig    o_cos
);
    localparam int LOWB = 32 - ANGLE_BITS;
    localparam logic [31:0] MASK = ~((32'd1 << LOWB) - 32'd1);

    logic signed [33:0] r_x [0:STAGES];
    logic signed [33:0] r_y [0:STAGES];
    logic signed [33:0] r_z [0:STAGES];
    logic               r_neg [0:STAGES];
    g2e_pkg::t_trig     r_sin, r_cos;

    logic [31:0]        trunc;
    logic signed [33:0] z_ext, n_z0;
    logic               n_neg0;

    // truncate, then fold into +-90 degrees
    always_comb begin
        trunc  = i_angle & MASK;
        z_ext  = {{2{trunc[31]}}, trunc};
        n_z0   = z_ext;
        n_neg0 = 1'b0;
        if (z_ext > g2e_pkg::Q30_ONE) begin
            n_z0   = z_ext - (g2e_pkg::Q30_ONE <<< 1);
            n_neg0 = 1'b1;
        end else if (z_ext < -g2e_pkg::Q30_ONE) begin
            n_z0   = z_ext + (g2e_pkg::Q30_ONE <<< 1);
            n_neg0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= g2e_pkg::CORDIC_GAIN;
            r_y[0]   <= '0;
            r_z[0]   <= n_z0;
            r_neg[0] <= n_neg0;
        end
    end

    for (genvar gi = 0; gi < STAGES; gi++) begin : g_stage
        localparam logic signed [33:0] ATN = {2'b00, g2e_pkg::ATAN_TURNS[gi]};
        logic signed [33:0] n_x, n_y, n_z;
        always_comb begin
            if (!r_z[gi][33]) begin
                n_x = r_x[gi] - (r_y[gi] >>> gi);
                n_y = r_y[gi] + (r_x[gi] >>> gi);
                n_z = r_z[gi] - ATN;
            end else begin
                n_x = r_x[gi] + (r_y[gi] >>> gi);
                n_y = r_y[gi] - (r_x[gi] >>> gi);
                n_z = r_z[gi] + ATN;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[gi+1]   <= n_x;
                r_y[gi+1]   <= n_y;
                r_z[gi+1]   <= n_z;
                r_neg[gi+1] <= r_neg[gi];
            end
        end
    end

    logic signed [33:0] n_s, n_c;
    always_comb begin
        n_s = r_neg[STAGES] ? -r_y[STAGES] : r_y[STAGES];
        n_c = r_neg[STAGES] ? -r_x[STAGES] : r_x[STAGES];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= n_s[31:0];
            r_cos <= n_c[31:0];
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;
endmodule

>>> rtl/core/g2e_radius.sv
// Prime vertical radius N = round(a * 2^31 / isqrt(w * 2^30)).
// Depends on g2e_pkg. Digit pipelines: 32 root stages, 35 quotient stages, one rounding stage.
module g2e_radius (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [32:0]                   i_w,
    input  logic [g2e_pkg::AXIS_W-1:0]    i_axis,
    output logic [g2e_pkg::N_W-1:0]       o_n
);
    localparam int SQ = g2e_pkg::SQRT_STAGES;
    localparam int DV = g2e_pkg::DIV_STAGES;

    // square root, two radicand bits per stage
    logic [32:0] r_sw   [0:SQ-1];
    logic [33:0] r_srem [0:SQ-1];
    logic [31:0] r_root [0:SQ-1];

    for (genvar gk = 0; gk < SQ; gk++) begin : g_sqrt
        localparam int P = SQ - 1 - gk;
        logic [32:0] w_in;
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic [63:0] v;
        logic [35:0] sh, trial;
        logic [33:0] n_rem;
        logic [31:0] n_root;
        if (gk == 0) begin : g_first
            assign w_in    = i_w;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign w_in    = r_sw[gk-1];
            assign rem_in  = r_srem[gk-1];
            assign root_in = r_root[gk-1];
        end
        always_comb begin
            v     = {1'b0, w_in, 30'd0};
            sh    = {rem_in, v[2*P +: 2]};
            trial = {2'b00, root_in, 2'b01};
            if (sh >= trial) begin
                n_rem  = 34'(sh - trial);
                n_root = {root_in[30:0], 1'b1};
            end else begin
                n_rem  = sh[33:0];
                n_root = {root_in[30:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sw[gk]   <= w_in;
                r_srem[gk] <= n_rem;
                r_root[gk] <= n_root;
            end
        end
    end

    // restoring division of a * 2^30 by the root, one quotient bit per stage
    logic [31:0] r_div [0:DV-1];
    logic [31:0] r_rem [0:DV-1];
    logic [34:0] r_q   [0:DV-1];

    for (genvar gj = 0; gj < DV; gj++) begin : g_div
        logic [31:0] d_in, rem_in;
        logic [34:0] q_in;
        logic        dbit;
        logic [32:0] sh;
        logic [31:0] n_rem;
        logic [34:0] n_q;
        if (gj == 0) begin : g_first
            assign d_in   = (r_root[SQ-1] == '0) ? 32'd1 : r_root[SQ-1];
            assign rem_in = {4'd0, i_axis[32:5]};
            assign q_in   = '0;
        end else begin : g_next
            assign d_in   = r_div[gj-1];
            assign rem_in = r_rem[gj-1];
            assign q_in   = r_q[gj-1];
        end
        if (gj < 5) begin : g_abit
            assign dbit = i_axis[4-gj];
        end else begin : g_zbit
            assign dbit = 1'b0;
        end
        always_comb begin
            sh = {rem_in, dbit};
            if (sh >= {1'b0, d_in}) begin
                n_rem = 32'(sh - {1'b0, d_in});
                n_q   = {q_in[33:0], 1'b1};
            end else begin
                n_rem = sh[31:0];
                n_q   = {q_in[33:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_div[gj] <= d_in;
                r_rem[gj] <= n_rem;
                r_q[gj]   <= n_q;
            end
        end
    end

    localparam int N_W_L = g2e_pkg::N_W;
    logic [35:0] n_n;
    logic [N_W_L-1:0] r_n;

    always_comb begin
        n_n = {r_q[DV-1], 1'b0}
            + (({r_rem[DV-1], 1'b0} >= {1'b0, r_div[DV-1]}) ? 36'd1 : 36'd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n <= n_n[N_W_L-1:0];
        end
    end

    assign o_n = r_n;
endmodule

>>> bench/geodetic_to_ecef_test.sv
// Self-checking bench for geodetic_to_ecef: geodetic points in, ECEF points out.
// Depends on g2e_pkg, g2e_in_if, g2e_out_if and the converter RTL.
`timescale 1ns / 100ps

module geodetic_to_ecef_test;

    localparam int    ANG_BITS    = 32;
    localparam int    ROT_STAGES  = 24;
    localparam int    PIPE_DEPTH  = ROT_STAGES + 79;   // pipeline depth, as LAT in the RTL
    localparam int    PHASE_ITEMS = 340;
    localparam int    NUM_PHASES  = 5;
    localparam int    HOLD_CYCLES = 400;
    localparam longint WGS_AXIS   = 64'd6378137000;
    localparam longint WGS_ECC    = 64'd28752143;

    typedef struct {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } t_ecef_pt;

    // Holds the current ellipsoid, predicts each point and checks results in order.
    class ecef_scoreboard;
        longint unsigned axis_mm;
        longint unsigned ecc_frac;
        t_ecef_pt        pending_q[$];
        int              errors;
        int              checked;

        function void set_ellipsoid(longint unsigned a, longint unsigned e);
            axis_mm  = a;
            ecc_frac = e;
        endfunction

        // v * f / 2^30, rounded half away from zero
        function longint scale_q30(longint v, longint f);
            bit               neg;
            bit [127:0]       prod;
            longint unsigned  av;
            longint unsigned  bf;
            neg  = (v < 0) != (f < 0);
            av   = (v < 0) ? -v : v;
            bf   = (f < 0) ? -f : f;
            prod = (128'(av) * 128'(bf) + (128'd1 << 29)) >> 30;
            return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
        endfunction

        function longint unsigned floor_root(longint unsigned v);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b   = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v   = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        // rotation-mode sin/cos, Q30; angles past +-90 deg folded and negated
        function void sin_cos(bit [31:0] raw, output longint sn, output longint cs);
            bit [31:0] low;
            longint    z;
            longint    x;
            longint    y;
            longint    dx;
            longint    dy;
            bit        neg;
            low = (ANG_BITS >= 32) ? 32'd0 : ((32'd1 << (32 - ANG_BITS)) - 1);
            z   = longint'($signed(raw & ~low));
            x   = 652032874;
            y   = 0;
            neg = 0;
            if (z > (64'sd1 <<< 30)) begin
                z   = z - (64'sd1 <<< 31);
                neg = 1;
            end else if (z < -(64'sd1 <<< 30)) begin
                z   = z + (64'sd1 <<< 31);
                neg = 1;
            end
            for (int i = 0; i < ROT_STAGES && i < 32; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx; y = y + dy; z = z - longint'(g2e_pkg::ATAN_TURNS[i]);
                end else begin
                    x = x + dx; y = y - dy; z = z + longint'(g2e_pkg::ATAN_TURNS[i]);
                end
            end
            if (neg) begin
                x = -x;
                y = -y;
            end
            sn = y;
            cs = x;
        endfunction

        function logic signed [33:0] clamp34(longint v);
            if (v > 64'sd8589934591) return 34'sh1_FFFF_FFFF;
            if (v < -64'sd8589934592) return -34'sh2_0000_0000;
            return v[33:0];
        endfunction

        // accepted input beat: compute the expected ECEF point
        function void note_point(bit [31:0] lat, bit [31:0] lon, bit [27:0] h_raw);
            longint          sl, cl, so, co, h, nh, zt;
            longint unsigned s2, t, w, r, q, rem, n, e2n;
            t_ecef_pt        e;
            sin_cos(lat, sl, cl);
            sin_cos(lon, so, co);
            h   = longint'($signed(h_raw));
            s2  = scale_q30(sl, sl);
            t   = (ecc_frac * s2) >> 30;
            w   = (64'd1 << 32) - t;
            r   = floor_root(w << 30);
            if (r == 0) r = 1;
            q   = (axis_mm << 30) / r;
            rem = (axis_mm << 30) % r;
            n   = 2 * q + ((2 * rem >= r) ? 1 : 0);     // rounded N in mm
            nh  = longint'(n) + h;
            e.x = clamp34(scale_q30(scale_q30(nh, cl), co));
            e.y = clamp34(scale_q30(scale_q30(nh, cl), so));
            e2n = (ecc_frac * n + (64'd1 << 31)) >> 32;
            zt  = longint'(n - e2n) + h;
            e.z = clamp34(scale_q30(zt, sl));
            pending_q.push_back(e);
        endfunction

        function void check_point(logic signed [33:0] x, logic signed [33:0] y,
                                  logic signed [33:0] z);
            t_ecef_pt e;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected ECEF beat x=%0d y=%0d z=%0d", $time, x, y, z);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            checked++;
            if (x !== e.x) begin
                $display("%0t: x_mm expected %0d got %0d", $time, e.x, x);
                errors++;
            end
            if (y !== e.y) begin
                $display("%0t: y_mm expected %0d got %0d", $time, e.y, y);
                errors++;
            end
            if (z !== e.z) begin
                $display("%0t: z_mm expected %0d got %0d", $time, e.z, z);
                errors++;
            end
        endfunction
    endclass

    logic                       i_clk = 0;
    logic                       i_rst_n = 0;
    logic                       i_cfg_we = 0;
    logic                       i_cfg_idx = g2e_pkg::CFG_AXIS;
    logic [g2e_pkg::CFG_W-1:0]  i_cfg_data = '0;

    g2e_in_if  pt ();
    g2e_out_if ecef ();

    geodetic_to_ecef DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pt       (pt),
        .o_ecef     (ecef)
    );

    ecef_scoreboard sb = new();
    bit calm     = 0;   // no random idling on either side
    bit hold_req = 0;   // ask the receiver for one long stall
    int sent     = 0;

    always #5 i_clk = ~i_clk;

    initial begin
        pt.valid     = 0;
        pt.latitude  = '0;
        pt.longitude = '0;
        pt.height_mm = '0;
        ecef.ready   = 0;
    end

    // both monitors sample pre-edge values, so ordering within the step is moot
    always @(posedge i_clk) begin
        if (i_rst_n && pt.valid && pt.ready)
            sb.note_point(pt.latitude, pt.longitude, pt.height_mm);
        if (i_rst_n && ecef.valid && ecef.ready)
            sb.check_point(ecef.x_mm, ecef.y_mm, ecef.z_mm);
    end

    // receiver: random backpressure, plus one long hold-off on request
    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 0;
                ecef.ready <= 0;
                for (int c = 0; c < HOLD_CYCLES; c++) @(posedge i_clk);
            end else begin
                ecef.ready <= calm || ($urandom_range(99) >= 29);
                @(posedge i_clk);
            end
        end
    end

    // one input beat; valid stays up across back-to-back beats
    task automatic send_point(bit [31:0] lat, bit [31:0] lon, bit [27:0] h);
        while (!calm && $urandom_range(99) < 29) begin
            pt.valid <= 0;
            @(posedge i_clk);
        end
        pt.valid     <= 1;
        pt.latitude  <= lat;
        pt.longitude <= lon;
        pt.height_mm <= h;
        do @(posedge i_clk); while (!pt.ready);
        sent++;
    endtask

    task automatic wait_drained();
        pt.valid <= 0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [g2e_pkg::CFG_W-1:0] data);
        i_cfg_we   <= 1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 0;
        if (idx == g2e_pkg::CFG_AXIS) sb.axis_mm  = data;
        else                          sb.ecc_frac = data[g2e_pkg::ECC_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic random_point();
        longint lat, lon, h;
        int     pick;
        pick = $urandom_range(9);
        lat  = longint'($urandom_range(32'd2147483648, 0)) - 64'sd1073741824;
        if (pick == 0)
            lat = ($urandom_range(1) ? 64'sd1073741824 : -64'sd1073741824)
                  - longint'($urandom_range(4096)) * ((lat < 0) ? -1 : 1);
        lon = longint'($signed($urandom()));
        h   = longint'($urandom_range(110000000, 0)) - 64'sd10000000;
        if (pick == 1) h = $urandom_range(1) ? 100000000 : -10000000;
        send_point(lat[31:0], lon[31:0], h[27:0]);
    endtask

    initial begin
        longint unsigned axis, ecc;
        sb.set_ellipsoid(WGS_AXIS, WGS_ECC);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: pole, equator, fold boundaries, longitude and height extremes
        send_point(32'sd1073741824, 32'sd0, 28'sd0);
        send_point(-32'sd1073741824, 32'sd0, 28'sd0);
        send_point(32'sd0, 32'sd0, 28'sd0);
        send_point(32'sd0, 32'h8000_0000, 28'sd100000000);
        send_point(32'sd0, 32'h7FFF_FFFF, -28'sd10000000);
        send_point(32'sd0, 32'sd1073741824, 28'sd0);
        send_point(32'sd0, 32'sd1073741825, 28'sd1);
        send_point(32'sd0, -32'sd1073741824, -28'sd1);
        send_point(32'sd0, -32'sd1073741825, 28'sd0);
        send_point(32'sd1073741823, 32'sd536870912, 28'sd100000000);
        send_point(-32'sd1073741823, -32'sd536870912, -28'sd10000000);
        send_point(32'sd357913941, 32'h5555_5555, 28'sd12345678);
        send_point(-32'sd357913941, 32'hAAAA_AAAA, -28'sd9999999);
        send_point(32'sd1, 32'hFFFF_FFFF, 28'sd0);
        send_point(-32'sd1, 32'sd1, 28'sd0);
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin axis = WGS_AXIS; ecc = WGS_ECC; end
                1: begin axis = 64'd7000000000; ecc = 0; end
                2: begin axis = 64'd6000000000; ecc = 67108863; end
                3: begin axis = WGS_AXIS; ecc = WGS_ECC | (64'h7F << g2e_pkg::ECC_W); end
                default: begin
                    axis = 64'd6000000000 + $urandom_range(1000000000);
                    ecc  = $urandom_range(67108863);
                end
            endcase
            write_reg(g2e_pkg::CFG_AXIS, axis[g2e_pkg::CFG_W-1:0]);
            write_reg(g2e_pkg::CFG_ECC, ecc[g2e_pkg::CFG_W-1:0]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                calm = (ph == 1 && k >= 100 && k < 250);
                if (ph == 2 && k == 100) hold_req = 1;   // sender keeps going
                random_point();
            end
            calm = 0;
            wait_drained();   // sender pauses until all results are in
        end

        $display("Sent %0d and converted %0d points over %0d ellipsoid settings,",
                 sent, sb.checked, NUM_PHASES + 1);
        $display("with fold boundaries, poles, random stalls and one long output hold-off.");
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("geodetic_to_ecef_test OK");
        end else begin
            $display("geodetic_to_ecef_test NOT OK");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("geodetic_to_ecef_test NOT OK");
        $finish;
    end

endmodule

>>> files.f
rtl/core/g2e_pkg.sv
rtl/core/g2e_in_if.sv
rtl/core/g2e_out_if.sv
rtl/core/g2e_cordic.sv
rtl/core/g2e_radius.sv
rtl/core/geodetic_to_ecef.sv
bench/geodetic_to_ecef_test.sv
